[hdl/hc3_pkg.sv]
// shared types, constants and base-path tables for the 3d hilbert index-to-coords core
`timescale 1ns / 1ps
package hc3_pkg;

  localparam int LEVEL_W           = 4;
  localparam int POS_W             = 24;
  localparam int COORD_W           = 8;
  localparam int MAX_LEVEL_DEFAULT = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd1;

  // base path point for each octal digit, bit d holds the coordinate of point d
  localparam logic [7:0] BASE_X = 8'b0011_1100;
  localparam logic [7:0] BASE_Y = 8'b0110_0110;
  localparam logic [7:0] BASE_Z = 8'b1111_0000;

  // control word that travels with each item down the pipe
  typedef struct packed {
    logic               valid;
    logic               range_err;
    logic [LEVEL_W-1:0] level;
  } hc3_ctl_t;

endpackage

[hdl/hc3_entry.sv]
// first pipe stage: range check and base-path point of the lowest digit
`timescale 1ns / 1ps
module hc3_entry
  import hc3_pkg::*;
#(
  parameter int MaxLevel = MAX_LEVEL_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [POS_W-1:0]        position,
  input  logic [LEVEL_W-1:0]      level,
  output hc3_ctl_t                ctl,
  output logic [3*MaxLevel-1:0]   pos,
  output logic [MaxLevel-1:0]     x,
  output logic [MaxLevel-1:0]     y,
  output logic [MaxLevel-1:0]     z
);

  localparam int PW = 3 * MaxLevel;
  localparam int CW = MaxLevel;

  logic                  range_err;
  logic [5:0]            limit;
  logic [PW+POS_W-1:0]   pos_wide;
  logic [2:0]            digit;

  // any set bit at or above 3*level puts the position out of range
  always_comb begin
    limit     = 6'(level) * 6'd3;
    range_err = 1'b0;
    for (int i = 0; i < POS_W; i++) begin
      if (position[i] && (6'(i) >= limit)) begin
        range_err = 1'b1;
      end
    end
  end

  assign pos_wide = {{PW{1'b0}}, position};
  assign digit    = position[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid     <= accept;
      ctl.range_err <= range_err;
      ctl.level     <= level;
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_wide[PW-1:0];
    x   <= CW'(BASE_X[digit]);
    y   <= CW'(BASE_Y[digit]);
    z   <= CW'(BASE_Z[digit]);
  end

endmodule

[hdl/hc3_step.sv]
// one octant stage: places the inner point into the octant picked by digit k
`timescale 1ns / 1ps
module hc3_step
  import hc3_pkg::*;
#(
  parameter int MaxLevel = MAX_LEVEL_DEFAULT,
  parameter int K        = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  hc3_ctl_t                ctl_in,
  input  logic [3*MaxLevel-1:0]   pos_in,
  input  logic [MaxLevel-1:0]     x_in,
  input  logic [MaxLevel-1:0]     y_in,
  input  logic [MaxLevel-1:0]     z_in,
  output hc3_ctl_t                ctl,
  output logic [3*MaxLevel-1:0]   pos,
  output logic [MaxLevel-1:0]     x,
  output logic [MaxLevel-1:0]     y,
  output logic [MaxLevel-1:0]     z
);

  localparam int CW = MaxLevel;
  localparam logic [CW-1:0] SIDE = CW'(1) << K;
  localparam logic [CW-1:0] MASK = SIDE - CW'(1);

  logic [2:0]    digit;
  logic          active;
  logic [CW-1:0] nx, ny, nz;
  logic [CW-1:0] x_next, y_next, z_next;

  assign digit  = pos_in[3*K +: 3];
  assign active = int'(ctl_in.level) > K;

  always_comb begin
    case (digit) inside
      3'd0: begin
        nx = y_in;        ny = z_in;        nz = x_in;
      end
      3'd1, 3'd2: begin
        nx = z_in;        ny = x_in;        nz = y_in;
      end
      3'd3, 3'd4: begin
        nx = MASK - x_in; ny = MASK - y_in; nz = z_in;
      end
      3'd5, 3'd6: begin
        nx = MASK - z_in; ny = x_in;        nz = MASK - y_in;
      end
      default: begin
        nx = y_in;        ny = MASK - z_in; nz = MASK - x_in;
      end
    endcase
    if (active) begin
      x_next = nx + (CW'(BASE_X[digit]) << K);
      y_next = ny + (CW'(BASE_Y[digit]) << K);
      z_next = nz + (CW'(BASE_Z[digit]) << K);
    end else begin
      x_next = x_in;
      y_next = y_in;
      z_next = z_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_in;
    x   <= x_next;
    y   <= y_next;
    z   <= z_next;
  end

endmodule

[hdl/hilbert_3d_index_to_coords_core.sv]
// top level of the 3d hilbert curve position-to-coordinates pipeline
`timescale 1ns / 1ps
//
//  channel   signals                                   direction  transfer when
//  --------  ----------------------------------------  ---------  -------------------
//  command   start, busy, curve_position               in         start && !busy
//  result    done, coord_x, coord_y, coord_z,          out        done (one cycle)
//            range_error
//  config    cfg_we, cfg_data (curve_level)            in         cfg_we
//
//  the pipe has one entry stage (range check, base point)
//  followed by MaxLevel-1 octant stages, one per higher octal digit
//  a new position can enter every cycle; busy is only high during reset
//  rst is synchronous and clears all stage valid bits and sets curve_level to 1
//  the receiver cannot stall, so results leave the last stage as they arrive
//
module hilbert_3d_index_to_coords_core
  import hc3_pkg::*;
#(
  parameter int MaxLevel = MAX_LEVEL_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [POS_W-1:0]    curve_position,
  input  logic                cfg_we,
  input  logic [LEVEL_W-1:0]  cfg_data,
  output logic                done,
  output logic [COORD_W-1:0]  coord_x,
  output logic [COORD_W-1:0]  coord_y,
  output logic [COORD_W-1:0]  coord_z,
  output logic                range_error
);

  localparam int PW   = 3 * MaxLevel;
  localparam int CW   = MaxLevel;
  localparam int LAST = MaxLevel - 1;

  // configuration register, raw value as written
  logic [LEVEL_W-1:0] curve_level;
  // effective level after clamping zero to one and large values to MaxLevel
  logic [LEVEL_W-1:0] level_eff;

  // per-stage pipeline registers, stage 0 is the entry stage
  hc3_ctl_t        ctl_s [MaxLevel];
  logic [PW-1:0]   pos_s [MaxLevel];
  logic [CW-1:0]   x_s   [MaxLevel];
  logic [CW-1:0]   y_s   [MaxLevel];
  logic [CW-1:0]   z_s   [MaxLevel];

  // coordinates widened so they can be cut to 8 bits at any MaxLevel
  logic [CW+COORD_W-1:0] x_wide, y_wide, z_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_level <= LEVEL_RESET;
    end else if (cfg_we) begin
      curve_level <= cfg_data;
    end
  end

  always_comb begin
    level_eff = curve_level;
    if (curve_level == '0) begin
      level_eff = LEVEL_W'(1);
    end else if (int'(curve_level) > MaxLevel) begin
      level_eff = LEVEL_W'(MaxLevel);
    end
  end

  // the pipe never stalls, so it only refuses commands while in reset
  assign busy = rst;

  hc3_entry #(
    .MaxLevel (MaxLevel)
  ) u_entry (
    .clk      (clk),
    .rst      (rst),
    .accept   (start && !busy),
    .position (curve_position),
    .level    (level_eff),
    .ctl      (ctl_s[0]),
    .pos      (pos_s[0]),
    .x        (x_s[0]),
    .y        (y_s[0]),
    .z        (z_s[0])
  );

  // one octant stage per higher digit; stages beyond the level pass through
  for (genvar k = 1; k < MaxLevel; k++) begin : g_step
    hc3_step #(
      .MaxLevel (MaxLevel),
      .K        (k)
    ) u_step (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ctl_s[k-1]),
      .pos_in (pos_s[k-1]),
      .x_in   (x_s[k-1]),
      .y_in   (y_s[k-1]),
      .z_in   (z_s[k-1]),
      .ctl    (ctl_s[k]),
      .pos    (pos_s[k]),
      .x      (x_s[k]),
      .y      (y_s[k]),
      .z      (z_s[k])
    );
  end

  // out-of-range positions report zero coordinates
  assign x_wide = ctl_s[LAST].range_err ? '0 : {{COORD_W{1'b0}}, x_s[LAST]};
  assign y_wide = ctl_s[LAST].range_err ? '0 : {{COORD_W{1'b0}}, y_s[LAST]};
  assign z_wide = ctl_s[LAST].range_err ? '0 : {{COORD_W{1'b0}}, z_s[LAST]};

  assign done        = ctl_s[LAST].valid;
  assign range_error = ctl_s[LAST].range_err;
  assign coord_x     = x_wide[COORD_W-1:0];
  assign coord_y     = y_wide[COORD_W-1:0];
  assign coord_z     = z_wide[COORD_W-1:0];

  // every accepted command yields its result once it has passed the entry stage and all octant stages
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(MaxLevel) done)
    else $error("result strobe missing at fixed latency");

  // out-of-range result carries zero coordinates
  a_range_zero : assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (coord_x == '0 && coord_y == '0 && coord_z == '0))
    else $error("out-of-range result with nonzero coordinates");

  // an in-range point stays inside the cube of side 2^level
  a_in_cube : assert property (@(posedge clk) disable iff (rst)
    (done && !range_error) |->
      (((16'(coord_x) >> level_eff) == 16'd0) &&
       ((16'(coord_y) >> level_eff) == 16'd0) &&
       ((16'(coord_z) >> level_eff) == 16'd0)))
    else $error("coordinate outside the cube");

endmodule
